[rtl/cwas_pkg.sv]
package cwas_pkg;

    // Event kinds carried on the request side
    typedef enum logic [1:0] {
        CMD_TICK      = 2'd0,
        CMD_SET_TIME  = 2'd1,
        CMD_SET_ALARM = 2'd2,
        CMD_BUTTON    = 2'd3
    } cmd_t;

    // Front-panel buttons
    typedef enum logic [1:0] {
        BTN_EXIT   = 2'd0,
        BTN_SELECT = 2'd1,
        BTN_INC    = 2'd2,
        BTN_NONE   = 2'd3
    } button_t;

    // Operating modes; codes match the result field
    typedef enum logic [1:0] {
        MODE_NORMAL    = 2'd0,
        MODE_SET_TIME  = 2'd1,
        MODE_SET_ALARM = 2'd2,
        MODE_UNUSED    = 2'd3
    } mode_t;

    // Field being edited
    typedef enum logic [1:0] {
        FIELD_SEC  = 2'd0,
        FIELD_MIN  = 2'd1,
        FIELD_HOUR = 2'd2,
        FIELD_RSVD = 2'd3
    } field_t;

    // Configuration register indexes
    localparam logic [1:0] REG_TICKS_PER_SEC = 2'd0;
    localparam logic [1:0] REG_SNOOZE_MIN    = 2'd1;
    localparam logic [1:0] REG_BLINK_PERIOD  = 2'd2;
    localparam logic [1:0] REG_BLINK_ON      = 2'd3;

    localparam int CFG_DATA_W = 16;
    localparam int RESULT_W   = 40;

    // Reset values
    localparam logic [15:0] RST_TICKS_PER_SEC = 16'd100;
    localparam logic [5:0]  RST_SNOOZE_MIN    = 6'd5;
    localparam logic [7:0]  RST_BLINK_PERIOD  = 8'd20;
    localparam logic [7:0]  RST_BLINK_ON      = 8'd5;
    localparam logic [4:0]  RST_HOURS         = 5'd12;
    localparam logic [5:0]  RST_MINUTES       = 6'd34;
    localparam logic [5:0]  RST_SECONDS       = 6'd50;
    localparam logic [4:0]  RST_ALARM_HOURS   = 5'd12;
    localparam logic [5:0]  RST_ALARM_MINUTES = 6'd35;
    localparam logic [5:0]  RST_ALARM_SECONDS = 6'd11;

    localparam logic [4:0] HOURS_PER_DAY = 5'd24;
    localparam logic [5:0] MINS_PER_HOUR = 6'd60;
    localparam logic [5:0] SECS_PER_MIN  = 6'd60;

    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
    } hms_t;

    // Configuration write request
    typedef struct packed {
        logic                  valid;
        logic [1:0]            index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

    // Result item, first field in the highest bits
    typedef struct packed {
        logic       led_on;
        logic       ringing;
        logic [5:0] alarm_seconds;
        logic [5:0] alarm_minutes;
        logic [4:0] alarm_hours;
        logic [5:0] seconds;
        logic [5:0] minutes;
        logic [4:0] hours;
        logic [1:0] field_select;
        logic [1:0] mode;
    } result_t;

    function automatic hms_t bump_hour(input hms_t t);
        hms_t r;
        r = t;
        r.hours = (t.hours + 5'd1 >= HOURS_PER_DAY) ? 5'd0 : t.hours + 5'd1;
        return r;
    endfunction

    function automatic hms_t bump_minute(input hms_t t);
        hms_t r;
        r = t;
        if (t.minutes + 6'd1 >= MINS_PER_HOUR)
        begin
            r.minutes = 6'd0;
            r = bump_hour(r);
        end
        else
        begin
            r.minutes = t.minutes + 6'd1;
        end
        return r;
    endfunction

    function automatic hms_t bump_second(input hms_t t);
        hms_t r;
        r = t;
        if (t.seconds + 6'd1 >= SECS_PER_MIN)
        begin
            r.seconds = 6'd0;
            r = bump_minute(r);
        end
        else
        begin
            r.seconds = t.seconds + 6'd1;
        end
        return r;
    endfunction

    function automatic hms_t bump_field(input hms_t t, input field_t f);
        hms_t r;
        case (f)
            FIELD_SEC: r = bump_second(t);
            FIELD_MIN: r = bump_minute(t);
            default:   r = bump_hour(t);
        endcase
        return r;
    endfunction

endpackage

[rtl/cwas_core.sv]
module cwas_core
    import cwas_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    accept,
    input  cmd_t    cmd,
    input  button_t button,
    input  cfg_wr_t cfg_wr,
    output result_t result
);

    logic [15:0] tps_reg;
    logic [5:0]  snooze_reg;
    logic [7:0]  period_reg;
    logic [7:0]  on_ticks_reg;

    mode_t       mode_reg, mode_next;
    field_t      field_reg, field_next;
    logic [15:0] tick_reg, tick_next;
    hms_t        time_reg, time_next;
    hms_t        alarm_reg, alarm_next;
    logic        ring_reg, ring_next;
    logic [7:0]  blink_reg, blink_next;

    logic [16:0] tick_inc;
    logic [8:0]  blink_inc;
    logic        matched;
    logic [6:0]  snz_sum;
    logic [5:0]  snz_min;
    logic [1:0]  snz_carry;
    logic [5:0]  snz_hour;

    // Snooze: add minutes with up to two hour carries
    always_comb
    begin
        snz_sum = {1'b0, alarm_reg.minutes} + {1'b0, snooze_reg};
        if (snz_sum >= 7'd120)
        begin
            snz_min   = 6'(snz_sum - 7'd120);
            snz_carry = 2'd2;
        end
        else if (snz_sum >= 7'd60)
        begin
            snz_min   = 6'(snz_sum - 7'd60);
            snz_carry = 2'd1;
        end
        else
        begin
            snz_min   = snz_sum[5:0];
            snz_carry = 2'd0;
        end
        snz_hour = {1'b0, alarm_reg.hours} + {4'd0, snz_carry};
        if (snz_hour >= {1'b0, HOURS_PER_DAY})
        begin
            snz_hour = snz_hour - {1'b0, HOURS_PER_DAY};
        end
    end

    // Next state for one event
    always_comb
    begin
        mode_next  = mode_reg;
        field_next = field_reg;
        tick_next  = tick_reg;
        time_next  = time_reg;
        alarm_next = alarm_reg;
        ring_next  = ring_reg;
        blink_next = blink_reg;
        tick_inc   = {1'b0, tick_reg} + 17'd1;
        blink_inc  = {1'b0, blink_reg} + 9'd1;
        matched    = 1'b0;

        case (cmd)
            CMD_TICK:
            begin
                if (mode_reg != MODE_SET_TIME)
                begin
                    if (tick_inc >= {1'b0, tps_reg})
                    begin
                        tick_next = 16'd0;
                        time_next = bump_second(time_reg);
                        matched   = (mode_reg == MODE_NORMAL) && !ring_reg &&
                                    (time_next == alarm_reg);
                    end
                    else
                    begin
                        tick_next = tick_inc[15:0];
                    end
                end
                if (matched)
                begin
                    ring_next  = 1'b1;
                    blink_next = 8'd0;
                end
                else if (ring_reg)
                begin
                    blink_next = (blink_inc >= {1'b0, period_reg}) ? 8'd0 : blink_inc[7:0];
                end
            end
            CMD_SET_TIME, CMD_SET_ALARM:
            begin
                mode_next  = mode_t'(cmd);
                field_next = FIELD_SEC;
            end
            default:
            begin
                if (mode_reg == MODE_NORMAL)
                begin
                    if (ring_reg && button != BTN_NONE)
                    begin
                        ring_next  = 1'b0;
                        blink_next = 8'd0;
                        if (button == BTN_EXIT)
                        begin
                            alarm_next.minutes = snz_min;
                            alarm_next.hours   = snz_hour[4:0];
                        end
                    end
                end
                else
                begin
                    case (button)
                        BTN_EXIT:   mode_next = MODE_NORMAL;
                        BTN_SELECT: field_next = (field_reg >= FIELD_HOUR) ? FIELD_SEC :
                                                 field_t'(field_reg + 2'd1);
                        BTN_INC:
                        begin
                            if (mode_reg == MODE_SET_TIME)
                            begin
                                time_next = bump_field(time_reg, field_reg);
                            end
                            else
                            begin
                                alarm_next = bump_field(alarm_reg, field_reg);
                            end
                        end
                        default: ;
                    endcase
                end
            end
        endcase
    end

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg      <= RST_TICKS_PER_SEC;
            snooze_reg   <= RST_SNOOZE_MIN;
            period_reg   <= RST_BLINK_PERIOD;
            on_ticks_reg <= RST_BLINK_ON;
        end
        else if (cfg_wr.valid)
        begin
            case (cfg_wr.index)
                REG_TICKS_PER_SEC: tps_reg      <= cfg_wr.data;
                REG_SNOOZE_MIN:    snooze_reg   <= cfg_wr.data[5:0];
                REG_BLINK_PERIOD:  period_reg   <= cfg_wr.data[7:0];
                REG_BLINK_ON:      on_ticks_reg <= cfg_wr.data[7:0];
                default: ;
            endcase
        end
    end

    // Advance clock state on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_NORMAL;
            field_reg <= FIELD_SEC;
            tick_reg  <= 16'd0;
            time_reg  <= '{hours: RST_HOURS, minutes: RST_MINUTES, seconds: RST_SECONDS};
            alarm_reg <= '{hours: RST_ALARM_HOURS, minutes: RST_ALARM_MINUTES,
                           seconds: RST_ALARM_SECONDS};
            ring_reg  <= 1'b0;
            blink_reg <= 8'd0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            field_reg <= field_next;
            tick_reg  <= tick_next;
            time_reg  <= time_next;
            alarm_reg <= alarm_next;
            ring_reg  <= ring_next;
            blink_reg <= blink_next;
        end
    end

    // Result reflects state after the update
    always_comb
    begin
        result.mode          = mode_next;
        result.field_select  = field_next;
        result.hours         = time_next.hours;
        result.minutes       = time_next.minutes;
        result.seconds       = time_next.seconds;
        result.alarm_hours   = alarm_next.hours;
        result.alarm_minutes = alarm_next.minutes;
        result.alarm_seconds = alarm_next.seconds;
        result.ringing       = ring_next;
        result.led_on        = ring_next && (blink_next < on_ticks_reg);
    end

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        time_reg.hours < HOURS_PER_DAY && time_reg.minutes < MINS_PER_HOUR &&
        time_reg.seconds < SECS_PER_MIN)
        else $error("time out of range");

    a_alarm_range: assert property (@(posedge clk) disable iff (!rst_n)
        alarm_reg.hours < HOURS_PER_DAY && alarm_reg.minutes < MINS_PER_HOUR &&
        alarm_reg.seconds < SECS_PER_MIN)
        else $error("alarm out of range");

    a_ring_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ring_reg) |-> mode_reg == MODE_NORMAL && blink_reg == 8'd0 &&
                            time_reg == alarm_reg)
        else $error("alarm started without a match in normal mode");

endmodule

[rtl/cwas_out_buf.sv]
module cwas_out_buf
    import cwas_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    main_valid_reg;
    result_t main_data_reg;
    logic    skid_valid_reg;
    result_t skid_data_reg;
    logic    push;
    logic    pop;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;
    assign push      = in_valid && in_ready;
    assign pop       = main_valid_reg && out_ready;

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= push;
            end
        end
        else if (push)
        begin
            if (main_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                main_valid_reg <= 1'b1;
            end
        end
    end

    // Payload: move skid forward or capture the new result
    always_ff @(posedge clk)
    begin
        if (pop && skid_valid_reg)
        begin
            main_data_reg <= skid_data_reg;
        end
        else if (push && (pop || !main_valid_reg))
        begin
            main_data_reg <= in_data;
        end
        if (push && main_valid_reg && !pop)
        begin
            skid_data_reg <= in_data;
        end
    end

    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid holds data while main stage empty");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && out_ready |=> !skid_valid_reg && main_valid_reg &&
                                        main_data_reg == $past(skid_data_reg))
        else $error("skid entry not moved forward");

endmodule

[rtl/clock_with_alarm_and_snooze.sv]
// A request's result is registered in the output buffer when it is accepted.
// Throughput: one request per cycle; the clock update is a single pass of logic
// between the state registers and a two-entry output buffer (main plus skid).
// s_tready falls only while both output entries wait on m_tready.
// Reset (rst_n, asynchronous): time 12:34:50, alarm 12:35:11, normal mode,
// not ringing, configuration at its defaults, output buffer empty.
module clock_with_alarm_and_snooze
    import cwas_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [1:0] button, [7:2] zero
    input  logic [1:0]            s_tuser,   // [1:0] cmd
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [1:0] mode, [3:2] field_select, [8:4] hours, [14:9] minutes,
    // [20:15] seconds, [25:21] alarm_hours, [31:26] alarm_minutes,
    // [37:32] alarm_seconds, [38] ringing, [39] led_on
    output logic [RESULT_W-1:0]   m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic    accept;
    cfg_wr_t cfg_wr;
    result_t core_result;
    result_t out_result;

    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;

    // Configuration write request
    always_comb
    begin
        cfg_wr.valid = cfg_valid && cfg_ready;
        cfg_wr.index = cfg_index;
        cfg_wr.data  = cfg_data;
    end

    cwas_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .cmd    (cmd_t'(s_tuser)),
        .button (button_t'(s_tdata[1:0])),
        .cfg_wr (cfg_wr),
        .result (core_result)
    );

    cwas_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (core_result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    assign m_tdata = out_result;

endmodule

[sim/clock_with_alarm_and_snooze_test.sv]
module clock_with_alarm_and_snooze_test
    import cwas_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;   // [1:0] button, [7:2] zero
    logic [1:0]            s_tuser   = '0;   // [1:0] cmd
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // [1:0] mode, [3:2] field_select, [8:4] hours, [14:9] minutes,
    // [20:15] seconds, [25:21] alarm_hours, [31:26] alarm_minutes,
    // [37:32] alarm_seconds, [38] ringing, [39] led_on
    logic [RESULT_W-1:0]   m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [1:0]            cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Clock state as the block should hold it
    mode_t       clk_mode;
    field_t      edit_field;
    logic [15:0] tick_cnt;
    hms_t        now_hms;
    hms_t        alarm_hms;
    bit          ringing_now;
    logic [7:0]  blink_cnt;

    // Configuration as last written
    logic [15:0] tps_cfg;
    logic [5:0]  snooze_cfg;
    logic [7:0]  period_cfg;
    logic [7:0]  lit_cfg;

    result_t display_q[$];
    int      errors        = 0;
    int      items_sent    = 0;
    int      send_idle_pct = 21;
    int      recv_idle_pct = 47;
    int      hold_left     = 0;

    clock_with_alarm_and_snooze DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // Receiver: stall at random, or hold off entirely while a long stall is pending
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Advance one unit of a time triple, carrying upwards
    function automatic hms_t step_field(hms_t t, int unit);
        int h;
        int m;
        int s;
        h = t.hours;
        m = t.minutes;
        s = t.seconds;
        if (unit == FIELD_SEC)
        begin
            s = s + 1;
            if (s >= 60)
            begin
                s = 0;
                unit = FIELD_MIN;
            end
            else
            begin
                unit = FIELD_RSVD;
            end
        end
        if (unit == FIELD_MIN)
        begin
            m = m + 1;
            if (m >= 60)
            begin
                m = 0;
                unit = FIELD_HOUR;
            end
            else
            begin
                unit = FIELD_RSVD;
            end
        end
        if (unit == FIELD_HOUR)
            h = (h + 1 >= 24) ? 0 : h + 1;
        return hms_t'{5'(h), 6'(m), 6'(s)};
    endfunction

    // Shift a time of day by a signed number of seconds
    function automatic hms_t offset_hms(hms_t t, int delta);
        int total;
        total = (int'(t.hours) * 3600 + int'(t.minutes) * 60 + int'(t.seconds) + delta)
                % 86400;
        if (total < 0)
            total = total + 86400;
        return hms_t'{5'(total / 3600), 6'((total / 60) % 60), 6'(total % 60)};
    endfunction

    function automatic int field_value(hms_t t, int f);
        if (f == FIELD_SEC)
            return t.seconds;
        else if (f == FIELD_MIN)
            return t.minutes;
        return t.hours;
    endfunction

    function automatic button_t any_button();
        return button_t'($urandom_range(3));
    endfunction

    task automatic reset_clock_state();
        clk_mode    = MODE_NORMAL;
        edit_field  = FIELD_SEC;
        tick_cnt    = '0;
        now_hms     = hms_t'{RST_HOURS, RST_MINUTES, RST_SECONDS};
        alarm_hms   = hms_t'{RST_ALARM_HOURS, RST_ALARM_MINUTES, RST_ALARM_SECONDS};
        ringing_now = 1'b0;
        blink_cnt   = '0;
        tps_cfg     = RST_TICKS_PER_SEC;
        snooze_cfg  = RST_SNOOZE_MIN;
        period_cfg  = RST_BLINK_PERIOD;
        lit_cfg     = RST_BLINK_ON;
    endtask

    // Apply one accepted request to the clock state and queue the display it gives
    task automatic update_clock(cmd_t c, button_t b);
        bit      started;
        int      next;
        int      mins;
        result_t disp;
        started = 1'b0;
        case (c)
            CMD_TICK:
            begin
                if (clk_mode != MODE_SET_TIME)
                begin
                    next = int'(tick_cnt) + 1;
                    if (next >= int'(tps_cfg))
                    begin
                        tick_cnt = '0;
                        now_hms  = step_field(now_hms, FIELD_SEC);
                        if (clk_mode == MODE_NORMAL && !ringing_now && now_hms == alarm_hms)
                        begin
                            ringing_now = 1'b1;
                            blink_cnt   = '0;
                            started     = 1'b1;
                        end
                    end
                    else
                    begin
                        tick_cnt = 16'(next);
                    end
                end
                if (ringing_now && !started)
                begin
                    next = int'(blink_cnt) + 1;
                    blink_cnt = (next >= int'(period_cfg)) ? 8'd0 : 8'(next);
                end
            end
            CMD_SET_TIME, CMD_SET_ALARM:
            begin
                clk_mode   = (c == CMD_SET_TIME) ? MODE_SET_TIME : MODE_SET_ALARM;
                edit_field = FIELD_SEC;
            end
            default:
            begin
                if (clk_mode == MODE_NORMAL)
                begin
                    // Only a real button while ringing does anything here
                    if (ringing_now && b != BTN_NONE)
                    begin
                        ringing_now = 1'b0;
                        blink_cnt   = '0;
                        if (b == BTN_EXIT)
                        begin
                            mins = int'(alarm_hms.minutes) + int'(snooze_cfg);
                            while (mins >= 60)
                            begin
                                mins = mins - 60;
                                alarm_hms = step_field(alarm_hms, FIELD_HOUR);
                            end
                            alarm_hms.minutes = 6'(mins);
                        end
                    end
                end
                else
                begin
                    case (b)
                        BTN_EXIT:   clk_mode = MODE_NORMAL;
                        BTN_SELECT: edit_field = (edit_field == FIELD_HOUR) ? FIELD_SEC
                                                 : field_t'(edit_field + 2'd1);
                        BTN_INC:
                        begin
                            if (clk_mode == MODE_SET_TIME)
                                now_hms = step_field(now_hms, edit_field);
                            else
                                alarm_hms = step_field(alarm_hms, edit_field);
                        end
                        default: ;
                    endcase
                end
            end
        endcase
        disp.mode          = clk_mode;
        disp.field_select  = edit_field;
        disp.hours         = now_hms.hours;
        disp.minutes       = now_hms.minutes;
        disp.seconds       = now_hms.seconds;
        disp.alarm_hours   = alarm_hms.hours;
        disp.alarm_minutes = alarm_hms.minutes;
        disp.alarm_seconds = alarm_hms.seconds;
        disp.ringing       = ringing_now;
        disp.led_on        = ringing_now && (blink_cnt < lit_cfg);
        display_q.push_back(disp);
    endtask

    // Offer one request, with random gaps before it, and hold it until taken
    task automatic send_event(cmd_t c, button_t b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c;
        s_tdata  <= {6'b0, b};
        do @(posedge clk); while (!s_tready);
        update_clock(c, b);
        items_sent++;
    endtask

    // Drop the request and let every pending display come out
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (display_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_TICKS_PER_SEC: tps_cfg    = val;
            REG_SNOOZE_MIN:    snooze_cfg = val[5:0];
            REG_BLINK_PERIOD:  period_cfg = val[7:0];
            default:           lit_cfg    = val[7:0];
        endcase
    endtask

    task automatic set_config(int tps, int snooze, int period, int lit);
        wait_drain();
        write_reg(REG_TICKS_PER_SEC, 16'(tps));
        write_reg(REG_SNOOZE_MIN, 16'(snooze));
        write_reg(REG_BLINK_PERIOD, 16'(period));
        write_reg(REG_BLINK_ON, 16'(lit));
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Enter a set mode, walk seconds, minutes, hours onto the goal, then leave
    task automatic steer_to(cmd_t which, hms_t goal);
        hms_t cur;
        send_event(which, any_button());
        for (int f = FIELD_SEC; f <= FIELD_HOUR; f++)
        begin
            cur = (which == CMD_SET_TIME) ? now_hms : alarm_hms;
            while (field_value(cur, f) != field_value(goal, f))
            begin
                send_event(CMD_BUTTON, BTN_INC);
                cur = (which == CMD_SET_TIME) ? now_hms : alarm_hms;
            end
            if (f != FIELD_HOUR)
                send_event(CMD_BUTTON, BTN_SELECT);
        end
        send_event(CMD_BUTTON, BTN_EXIT);
    endtask

    // Bring time and alarm a few seconds apart, tick into the alarm, then play with it
    task automatic ring_scenario();
        int lead;
        int guard;
        lead = $urandom_range(1, 4);
        if (ringing_now)
            send_event(CMD_BUTTON, button_t'($urandom_range(2)));
        if ($urandom_range(1))
            steer_to(CMD_SET_ALARM, offset_hms(now_hms, lead));
        else
            steer_to(CMD_SET_TIME, offset_hms(alarm_hms, -lead));
        guard = 0;
        while (!ringing_now && guard < 300)
        begin
            send_event(CMD_TICK, any_button());
            guard++;
        end
        repeat ($urandom_range(0, 30))
        begin
            case ($urandom_range(9))
                0: send_event(CMD_BUTTON, BTN_NONE);
                1:
                begin
                    // Set modes leave the ringing alone
                    send_event(cmd_t'($urandom_range(1, 2)), any_button());
                    send_event(CMD_TICK, any_button());
                    send_event(CMD_BUTTON, BTN_EXIT);
                end
                default: send_event(CMD_TICK, any_button());
            endcase
        end
        case ($urandom_range(3))
            0, 1: send_event(CMD_BUTTON, BTN_EXIT);
            2:    send_event(CMD_BUTTON, button_t'($urandom_range(1, 2)));
            default: ;
        endcase
    endtask

    task automatic noise_burst();
        repeat ($urandom_range(1, 8))
            send_event(cmd_t'($urandom_range(3)), any_button());
    endtask

    task automatic test_directed();
        send_event(CMD_TICK, BTN_NONE);
        send_event(CMD_BUTTON, BTN_NONE);
        send_event(CMD_BUTTON, BTN_EXIT);
        send_event(CMD_BUTTON, BTN_SELECT);
        send_event(CMD_BUTTON, BTN_INC);
        send_event(CMD_SET_TIME, BTN_NONE);
        send_event(CMD_TICK, BTN_EXIT);
        send_event(CMD_BUTTON, BTN_INC);
        send_event(CMD_BUTTON, BTN_SELECT);
        send_event(CMD_BUTTON, BTN_INC);
        send_event(CMD_BUTTON, BTN_SELECT);
        send_event(CMD_BUTTON, BTN_INC);
        send_event(CMD_BUTTON, BTN_SELECT);
        send_event(CMD_BUTTON, BTN_NONE);
        send_event(CMD_SET_ALARM, BTN_SELECT);
        send_event(CMD_TICK, BTN_INC);
        send_event(CMD_BUTTON, BTN_INC);
        send_event(CMD_BUTTON, BTN_SELECT);
        send_event(CMD_SET_TIME, BTN_INC);
        send_event(CMD_SET_ALARM, BTN_EXIT);
        send_event(CMD_BUTTON, BTN_EXIT);
    endtask

    // Shrink the prescale below the count reached, then the widest and zero settings
    task automatic test_prescaler();
        set_config(1000, 5, 20, 5);
        repeat (40) send_event(CMD_TICK, any_button());
        set_config(5, 5, 20, 5);
        repeat (3) send_event(CMD_TICK, any_button());
        set_config(65535, 0, 0, 255);
        repeat (6) send_event(CMD_TICK, any_button());
        set_config(0, 0, 0, 255);
        repeat (3) send_event(CMD_TICK, any_button());
    endtask

    // Ring on the last second of the day, roll over, and snooze past midnight with two hour carries
    task automatic test_midnight();
        set_config(1, 63, 3, 1);
        steer_to(CMD_SET_TIME, hms_t'{5'd23, 6'd59, 6'd57});
        steer_to(CMD_SET_ALARM, hms_t'{5'd23, 6'd59, 6'd59});
        repeat (4) send_event(CMD_TICK, any_button());
        send_event(CMD_BUTTON, BTN_EXIT);
        send_event(CMD_TICK, any_button());
    endtask

    // Hold the receiver off while requests keep coming, so the input stalls
    task automatic test_backpressure();
        int saved;
        saved = send_idle_pct;
        send_idle_pct = 0;
        hold_left = 150;
        repeat (40) send_event(CMD_TICK, any_button());
        send_idle_pct = saved;
    endtask

    task automatic test_random(int send_pct, int recv_pct, int count,
                               int tps, int snooze, int period, int lit);
        int start;
        set_config(tps, snooze, period, lit);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        start = items_sent;
        while (items_sent - start < count)
        begin
            if ($urandom_range(99) < 75)
                ring_scenario();
            else
                noise_burst();
        end
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Compare each display taken with the oldest one still pending
    always @(posedge clk)
    begin : check_display
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (display_q.size() == 0)
            begin
                $display("%0t: unexpected display expected none got %h", $time, got);
                errors++;
            end
            else
            begin
                want = display_q.pop_front();
                check_field("mode", want.mode, got.mode);
                check_field("field_select", want.field_select, got.field_select);
                check_field("hours", want.hours, got.hours);
                check_field("minutes", want.minutes, got.minutes);
                check_field("seconds", want.seconds, got.seconds);
                check_field("alarm_hours", want.alarm_hours, got.alarm_hours);
                check_field("alarm_minutes", want.alarm_minutes, got.alarm_minutes);
                check_field("alarm_seconds", want.alarm_seconds, got.alarm_seconds);
                check_field("ringing", want.ringing, got.ringing);
                check_field("led_on", want.led_on, got.led_on);
            end
        end
    end

    initial
    begin
        reset_clock_state();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_prescaler();
        test_midnight();
        test_backpressure();
        test_random(21, 47, 215, 1, 59, 4, 2);
        test_random(21, 47, 215, 2, 63, 0, 255);
        test_random(47, 21, 215, 3, 0, 255, 0);
        test_random(47, 21, 215, 0, 17, 7, 7);
        test_random(0, 0, 215, 1, 60, 1, 1);
        test_random(0, 0, 215, 2, 31, 9, 4);

        wait_drain();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #1000000;
        $display("simulation failed");
        $finish;
    end

endmodule
